// ===== hw/rtl/running_stats_merge_core_defines.svh =====
// ----------------------------------------------------------------------------
// running_stats_merge_core_defines
// assertion macros shared by the running statistics merge core
// ----------------------------------------------------------------------------
`ifndef RUNNING_STATS_MERGE_CORE_DEFINES_SVH
`define RUNNING_STATS_MERGE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RSM_ASSERT_IMP(lbl, a, c) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (a) |-> (c)) else $error("rsm assertion failed");
`define RSM_ASSERT_NXT(lbl, a, c) lbl: assert property (@(posedge i_clk) \
    disable iff (!i_rst_n) (a) |=> (c)) else $error("rsm assertion failed");
`else
`define RSM_ASSERT_IMP(lbl, a, c)
`define RSM_ASSERT_NXT(lbl, a, c)
`endif
`endif

// ===== hw/rtl/rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsm_pkg
// command, status and microcode definitions of the statistics merge core
// ----------------------------------------------------------------------------
`default_nettype none
package rsm_pkg;

    localparam int PC_BITS = 6;

    typedef logic [PC_BITS-1:0] t_pc;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLR, OP_MUL_LD, OP_MUL_STEP, OP_DIV_LD, OP_DIV_STEP,
        OP_SQRT_LD, OP_SQRT_STEP, OP_SAVE, OP_OUT
    } t_op;

    typedef enum logic [4:0] {
        SRC_NONE, SRC_N, SRC_M, SRC_NM1, SRC_MM1, SRC_T, SRC_TM1,
        SRC_AM, SRC_MC, SRC_AV, SRC_VC, SRC_AX, SRC_XC, SRC_AY, SRC_YC,
        SRC_D, SRC_T1, SRC_T2, SRC_DEN
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE, DST_T1, DST_T2, DST_DEN, DST_X, DST_Y, DST_POOL,
        DST_VAR, DST_VAR0, DST_MEAN, DST_CNT, DST_STD
    } t_dst;

    typedef enum logic [3:0] {
        U_CLR, U_MUL, U_DIV, U_SQRT, U_SAVE, U_BR_MZ, U_BR_SMALL, U_JMP, U_END
    } t_ukind;

    typedef struct packed {
        t_ukind kind;
        t_src   src_a;
        t_src   src_b;
        t_dst   dst;
    } t_uop;

    typedef struct packed {
        logic take;
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic t_small;
        logic mpl_zero;
        logic out_free;
    } t_sts;

    localparam t_pc PC_SMALL = t_pc'(31);
    localparam t_pc PC_MEAN  = t_pc'(32);

    function automatic t_uop rsm_uop(t_pc pc);
        t_uop u;
        u = '{U_END, SRC_NONE, SRC_NONE, DST_NONE};
        unique case (pc)
            6'd0:  u = '{U_BR_MZ,    SRC_NONE, SRC_NONE, DST_NONE};
            6'd1:  u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd2:  u = '{U_MUL,      SRC_AX,   SRC_N,    DST_NONE};
            6'd3:  u = '{U_MUL,      SRC_XC,   SRC_M,    DST_NONE};
            6'd4:  u = '{U_DIV,      SRC_T,    SRC_NONE, DST_NONE};
            6'd5:  u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_X};
            6'd6:  u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd7:  u = '{U_MUL,      SRC_AY,   SRC_N,    DST_NONE};
            6'd8:  u = '{U_MUL,      SRC_YC,   SRC_M,    DST_NONE};
            6'd9:  u = '{U_DIV,      SRC_T,    SRC_NONE, DST_NONE};
            6'd10: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_Y};
            6'd11: u = '{U_BR_SMALL, SRC_NONE, SRC_NONE, DST_NONE};
            6'd12: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd13: u = '{U_MUL,      SRC_AV,   SRC_NM1,  DST_NONE};
            6'd14: u = '{U_MUL,      SRC_VC,   SRC_MM1,  DST_NONE};
            6'd15: u = '{U_DIV,      SRC_TM1,  SRC_NONE, DST_NONE};
            6'd16: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_POOL};
            6'd17: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd18: u = '{U_MUL,      SRC_T,    SRC_TM1,  DST_NONE};
            6'd19: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_DEN};
            6'd20: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd21: u = '{U_MUL,      SRC_N,    SRC_M,    DST_NONE};
            6'd22: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_T1};
            6'd23: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd24: u = '{U_MUL,      SRC_D,    SRC_D,    DST_NONE};
            6'd25: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_T2};
            6'd26: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd27: u = '{U_MUL,      SRC_T1,   SRC_T2,   DST_NONE};
            6'd28: u = '{U_DIV,      SRC_DEN,  SRC_NONE, DST_NONE};
            6'd29: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_VAR};
            6'd30: u = '{U_JMP,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd31: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_VAR0};
            6'd32: u = '{U_CLR,      SRC_NONE, SRC_NONE, DST_NONE};
            6'd33: u = '{U_MUL,      SRC_AM,   SRC_N,    DST_NONE};
            6'd34: u = '{U_MUL,      SRC_MC,   SRC_M,    DST_NONE};
            6'd35: u = '{U_DIV,      SRC_T,    SRC_NONE, DST_NONE};
            6'd36: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_MEAN};
            6'd37: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_CNT};
            6'd38: u = '{U_SQRT,     SRC_NONE, SRC_NONE, DST_NONE};
            6'd39: u = '{U_SAVE,     SRC_NONE, SRC_NONE, DST_STD};
            default: u = '{U_END,    SRC_NONE, SRC_NONE, DST_NONE};
        endcase
        return u;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/running_stats_merge_core.sv =====
// ----------------------------------------------------------------------------
// running_stats_merge_core
// merges chunk count, mean, variance and position into a running summary
// ----------------------------------------------------------------------------
// One chunk summary is taken at a time and one result beat comes out for
// each. The single shared bit-serial divider runs W steps for each of the
// five divisions (three when the merged count is below two), where
// W = 2*COUNT_BITS + 2*(16+FRAC_BITS) + 2; each multiply steps through the
// bit length of its multiplier. An empty chunk skips the arithmetic and goes
// straight to its result beat. The result sits in an output register, so a
// stalled result only holds the next result back.
`default_nettype none
module running_stats_merge_core #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8,
    parameter int COORD_BITS = 16
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  wire                     i_start_req,
    input  wire [COUNT_BITS-1:0]    i_chunk_count,
    input  wire [16+FRAC_BITS-1:0]  i_chunk_mean,
    input  wire [32+FRAC_BITS-1:0]  i_chunk_variance,
    input  wire [COORD_BITS-1:0]    i_chunk_x,
    input  wire [COORD_BITS-1:0]    i_chunk_y,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output logic [COUNT_BITS-1:0]   o_total_count,
    output logic [16+FRAC_BITS-1:0] o_merged_mean,
    output logic [32+FRAC_BITS-1:0] o_merged_variance,
    output logic [16+FRAC_BITS-1:0] o_merged_std,
    output logic [COORD_BITS-1:0]   o_merged_x,
    output logic [COORD_BITS-1:0]   o_merged_y,
    output logic                    o_saturated
);
    rsm_pkg::t_cmd w_cmd;
    rsm_pkg::t_sts w_sts;

    rsm_controller #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rsm_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_start_req       (i_start_req),
        .i_chunk_count     (i_chunk_count),
        .i_chunk_mean      (i_chunk_mean),
        .i_chunk_variance  (i_chunk_variance),
        .i_chunk_x         (i_chunk_x),
        .i_chunk_y         (i_chunk_y),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_total_count     (o_total_count),
        .o_merged_mean     (o_merged_mean),
        .o_merged_variance (o_merged_variance),
        .o_merged_std      (o_merged_std),
        .o_merged_x        (o_merged_x),
        .o_merged_y        (o_merged_y),
        .o_saturated       (o_saturated)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/rsm_datapath.sv =====
// ----------------------------------------------------------------------------
// rsm_datapath
// summary registers and shared shift-add multiply, divide and root unit
// ----------------------------------------------------------------------------
`default_nettype none
module rsm_datapath #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8,
    parameter int COORD_BITS = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire rsm_pkg::t_cmd             i_cmd,
    output rsm_pkg::t_sts                  o_sts,
    input  wire                            i_start_req,
    input  wire [COUNT_BITS-1:0]           i_chunk_count,
    input  wire [16+FRAC_BITS-1:0]         i_chunk_mean,
    input  wire [32+FRAC_BITS-1:0]         i_chunk_variance,
    input  wire [COORD_BITS-1:0]           i_chunk_x,
    input  wire [COORD_BITS-1:0]           i_chunk_y,
    input  wire                            i_out_stall,
    output logic                           o_out_valid,
    output logic [COUNT_BITS-1:0]          o_total_count,
    output logic [16+FRAC_BITS-1:0]        o_merged_mean,
    output logic [32+FRAC_BITS-1:0]        o_merged_variance,
    output logic [16+FRAC_BITS-1:0]        o_merged_std,
    output logic [COORD_BITS-1:0]          o_merged_x,
    output logic [COORD_BITS-1:0]          o_merged_y,
    output logic                           o_saturated
);
    localparam int MW    = 16 + FRAC_BITS;
    localparam int VW    = 32 + FRAC_BITS;
    localparam int WW    = 2 * COUNT_BITS + 2 * MW + 2;
    localparam int SQ_SH = FRAC_BITS + WW - 2 * MW;

    logic [COUNT_BITS-1:0] r_m, r_n;
    logic [MW-1:0]         r_mc, r_am, r_sd;
    logic [VW-1:0]         r_vc, r_av;
    logic [COORD_BITS-1:0] r_xc, r_yc, r_ax, r_ay;
    logic                  r_sat;
    logic [WW-1:0]         r_acc, r_mca, r_mpl, r_t1, r_t2, r_den, r_pool;

    logic [COUNT_BITS:0]   w_t, w_tm1;
    logic [COUNT_BITS-1:0] w_nm1, w_mm1;
    logic [MW-1:0]         w_d;
    logic [WW-1:0]         w_a, w_b, w_rem2, w_srem, w_trial;
    logic [WW:0]           w_sum;
    logic                  w_var_sat;

    function automatic logic [WW-1:0] pick_src(rsm_pkg::t_src s);
        logic [WW-1:0] v;
        v = '0;
        unique case (s)
            rsm_pkg::SRC_N:    v = WW'(r_n);
            rsm_pkg::SRC_M:    v = WW'(r_m);
            rsm_pkg::SRC_NM1:  v = WW'(w_nm1);
            rsm_pkg::SRC_MM1:  v = WW'(w_mm1);
            rsm_pkg::SRC_T:    v = WW'(w_t);
            rsm_pkg::SRC_TM1:  v = WW'(w_tm1);
            rsm_pkg::SRC_AM:   v = WW'(r_am);
            rsm_pkg::SRC_MC:   v = WW'(r_mc);
            rsm_pkg::SRC_AV:   v = WW'(r_av);
            rsm_pkg::SRC_VC:   v = WW'(r_vc);
            rsm_pkg::SRC_AX:   v = WW'(r_ax);
            rsm_pkg::SRC_XC:   v = WW'(r_xc);
            rsm_pkg::SRC_AY:   v = WW'(r_ay);
            rsm_pkg::SRC_YC:   v = WW'(r_yc);
            rsm_pkg::SRC_D:    v = WW'(w_d);
            rsm_pkg::SRC_T1:   v = r_t1;
            rsm_pkg::SRC_T2:   v = r_t2;
            rsm_pkg::SRC_DEN:  v = r_den;
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        w_t       = {1'b0, r_n} + {1'b0, r_m};
        w_tm1     = w_t - 1'b1;
        w_nm1     = (r_n == '0) ? '0 : r_n - 1'b1;
        w_mm1     = r_m - 1'b1;
        w_d       = (r_am > r_mc) ? r_am - r_mc : r_mc - r_am;
        w_a       = pick_src(i_cmd.src_a);
        w_b       = pick_src(i_cmd.src_b);
        w_rem2    = {r_acc[WW-2:0], r_mpl[WW-1]};
        w_srem    = {r_acc[WW-3:0], r_mpl[WW-1:WW-2]};
        w_trial   = {r_mca[WW-3:0], 2'b01};
        w_sum     = {1'b0, r_pool} + {1'b0, r_mpl};
        w_var_sat = (w_sum[WW:VW] != '0);
    end

    assign o_sts.m_zero   = (r_m == '0);
    assign o_sts.t_small  = (w_t < (COUNT_BITS+1)'(2));
    assign o_sts.mpl_zero = (r_mpl == '0);
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    // running summary and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_am        <= '0;
            r_av        <= '0;
            r_ax        <= '0;
            r_ay        <= '0;
            r_sd        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take && i_start_req) begin
                r_n  <= '0;
                r_am <= '0;
                r_av <= '0;
                r_ax <= '0;
                r_ay <= '0;
                r_sd <= '0;
            end
            if (i_cmd.op == rsm_pkg::OP_SAVE) begin
                case (i_cmd.dst)
                    rsm_pkg::DST_X:    r_ax <= r_mpl[COORD_BITS-1:0];
                    rsm_pkg::DST_Y:    r_ay <= r_mpl[COORD_BITS-1:0];
                    rsm_pkg::DST_MEAN: r_am <= r_mpl[MW-1:0];
                    rsm_pkg::DST_VAR:  r_av <= w_var_sat ? {VW{1'b1}} : w_sum[VW-1:0];
                    rsm_pkg::DST_VAR0: r_av <= '0;
                    rsm_pkg::DST_CNT:  r_n  <= w_t[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                                              : w_t[COUNT_BITS-1:0];
                    rsm_pkg::DST_STD:  r_sd <= r_mca[MW-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == rsm_pkg::OP_OUT) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // chunk latch, arithmetic unit and output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_m   <= i_chunk_count;
            r_mc  <= i_chunk_mean;
            r_vc  <= i_chunk_variance;
            r_xc  <= i_chunk_x;
            r_yc  <= i_chunk_y;
            r_sat <= 1'b0;
        end
        unique case (i_cmd.op)
            rsm_pkg::OP_CLR: begin
                r_acc <= '0;
            end
            rsm_pkg::OP_MUL_LD: begin
                r_mca <= w_a;
                r_mpl <= w_b;
            end
            rsm_pkg::OP_MUL_STEP: begin
                if (r_mpl[0]) begin
                    r_acc <= r_acc + r_mca;
                end
                r_mca <= {r_mca[WW-2:0], 1'b0};
                r_mpl <= {1'b0, r_mpl[WW-1:1]};
            end
            rsm_pkg::OP_DIV_LD: begin
                r_mpl <= r_acc;
                r_acc <= '0;
                r_mca <= w_a;
            end
            rsm_pkg::OP_DIV_STEP: begin
                if (w_rem2 >= r_mca) begin
                    r_acc <= w_rem2 - r_mca;
                    r_mpl <= {r_mpl[WW-2:0], 1'b1};
                end else begin
                    r_acc <= w_rem2;
                    r_mpl <= {r_mpl[WW-2:0], 1'b0};
                end
            end
            rsm_pkg::OP_SQRT_LD: begin
                r_mpl <= WW'(r_av) << SQ_SH;
                r_acc <= '0;
                r_mca <= '0;
            end
            rsm_pkg::OP_SQRT_STEP: begin
                r_mpl <= {r_mpl[WW-3:0], 2'b00};
                if (w_srem >= w_trial) begin
                    r_acc <= w_srem - w_trial;
                    r_mca <= {r_mca[WW-2:0], 1'b1};
                end else begin
                    r_acc <= w_srem;
                    r_mca <= {r_mca[WW-2:0], 1'b0};
                end
            end
            rsm_pkg::OP_SAVE: begin
                case (i_cmd.dst)
                    rsm_pkg::DST_T1:   r_t1   <= r_acc;
                    rsm_pkg::DST_T2:   r_t2   <= r_acc;
                    rsm_pkg::DST_DEN:  r_den  <= r_acc << FRAC_BITS;
                    rsm_pkg::DST_POOL: r_pool <= r_mpl;
                    rsm_pkg::DST_VAR: begin
                        if (w_var_sat) begin
                            r_sat <= 1'b1;
                        end
                    end
                    rsm_pkg::DST_CNT: begin
                        if (w_t[COUNT_BITS]) begin
                            r_sat <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            rsm_pkg::OP_OUT: begin
                o_total_count     <= r_n;
                o_merged_mean     <= r_am;
                o_merged_variance <= r_av;
                o_merged_std      <= r_sd;
                o_merged_x        <= r_ax;
                o_merged_y        <= r_ay;
                o_saturated       <= r_sat;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/rsm_controller.sv =====
// ----------------------------------------------------------------------------
// rsm_controller
// microcode sequencer that drives the merge datapath
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_stats_merge_core_defines.svh"
module rsm_controller #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire rsm_pkg::t_sts i_sts,
    output rsm_pkg::t_cmd      o_cmd
);
    localparam int MW    = 16 + FRAC_BITS;
    localparam int WW    = 2 * COUNT_BITS + 2 * MW + 2;
    localparam int CNT_W = $clog2(WW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WW - 1);
    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(MW - 1);

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_DIV, S_SQRT, S_OUT} t_state;

    t_state           r_state;
    rsm_pkg::t_pc     r_pc;
    logic [CNT_W-1:0] r_cnt;
    rsm_pkg::t_uop    w_u;

    assign w_u        = rsm_pkg::rsm_uop(r_pc);
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

    always_comb begin
        o_cmd = '{1'b0, rsm_pkg::OP_NONE, rsm_pkg::SRC_NONE, rsm_pkg::SRC_NONE,
                  rsm_pkg::DST_NONE};
        unique case (r_state)
            S_IDLE: o_cmd.take = i_in_valid && i_rst_n;
            S_RUN: begin
                o_cmd.src_a = w_u.src_a;
                o_cmd.src_b = w_u.src_b;
                o_cmd.dst   = w_u.dst;
                unique case (w_u.kind)
                    rsm_pkg::U_CLR:  o_cmd.op = rsm_pkg::OP_CLR;
                    rsm_pkg::U_MUL:  o_cmd.op = rsm_pkg::OP_MUL_LD;
                    rsm_pkg::U_DIV:  o_cmd.op = rsm_pkg::OP_DIV_LD;
                    rsm_pkg::U_SQRT: o_cmd.op = rsm_pkg::OP_SQRT_LD;
                    rsm_pkg::U_SAVE: o_cmd.op = rsm_pkg::OP_SAVE;
                    default:         o_cmd.op = rsm_pkg::OP_NONE;
                endcase
            end
            S_MUL:   o_cmd.op = i_sts.mpl_zero ? rsm_pkg::OP_NONE : rsm_pkg::OP_MUL_STEP;
            S_DIV:   o_cmd.op = rsm_pkg::OP_DIV_STEP;
            S_SQRT:  o_cmd.op = rsm_pkg::OP_SQRT_STEP;
            S_OUT:   o_cmd.op = i_sts.out_free ? rsm_pkg::OP_OUT : rsm_pkg::OP_NONE;
            default: o_cmd.op = rsm_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_RUN;
                        r_pc    <= '0;
                    end
                end
                S_RUN: begin
                    r_cnt <= '0;
                    unique case (w_u.kind)
                        rsm_pkg::U_MUL:  r_state <= S_MUL;
                        rsm_pkg::U_DIV:  r_state <= S_DIV;
                        rsm_pkg::U_SQRT: r_state <= S_SQRT;
                        rsm_pkg::U_BR_MZ: begin
                            if (i_sts.m_zero) begin
                                r_state <= S_OUT;
                            end else begin
                                r_pc <= r_pc + 1'b1;
                            end
                        end
                        rsm_pkg::U_BR_SMALL: begin
                            r_pc <= i_sts.t_small ? rsm_pkg::PC_SMALL : r_pc + 1'b1;
                        end
                        rsm_pkg::U_JMP: r_pc <= rsm_pkg::PC_MEAN;
                        rsm_pkg::U_END: r_state <= S_OUT;
                        default:        r_pc <= r_pc + 1'b1;
                    endcase
                end
                S_MUL: begin
                    if (i_sts.mpl_zero) begin
                        r_state <= S_RUN;
                        r_pc    <= r_pc + 1'b1;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_RUN;
                        r_pc    <= r_pc + 1'b1;
                    end
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == SQ_LAST) begin
                        r_state <= S_RUN;
                        r_pc    <= r_pc + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RSM_ASSERT_NXT(a_take_starts, o_cmd.take, r_state == S_RUN && r_pc == '0)
    `RSM_ASSERT_IMP(a_div_count, r_state == S_DIV, r_cnt <= DIV_LAST)
    `RSM_ASSERT_IMP(a_sqrt_count, r_state == S_SQRT, r_cnt <= SQ_LAST)
    `RSM_ASSERT_NXT(a_mul_exit, r_state == S_MUL, r_state == S_MUL || r_state == S_RUN)

endmodule
`default_nettype wire
